// File: rtl/tcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_pkg: shared widths and types for the tangent circle placer
// Derived widths of the exact integer datapath and the tag records that ride
// along the pipelined multiplier, square root and divider.
// ----------------------------------------------------------------------------
package tcp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int RAD_WIDTH   = COORD_WIDTH - 1;
  localparam int EW          = COORD_WIDTH + 1;   // centre difference
  localparam int LW          = 2 * EW;            // squared length and squared sums
  localparam int NW          = LW + 2;            // signed N
  localparam int NMW         = NW - 1;            // magnitude of N
  localparam int QW          = 2 * LW;            // radicand
  localparam int SW          = QW / 2;            // root
  localparam int SRW         = SW + 4;            // root remainder
  localparam int MW          = NW;                // multiplier operand
  localparam int MUL_SEGS    = 4;
  localparam int SEGW        = (MW + MUL_SEGS - 1) / MUL_SEGS;
  localparam int MPW         = MUL_SEGS * SEGW;
  localparam int PW          = 2 * MPW;
  localparam int MUL_LAT     = 3;
  localparam int NUMW        = NMW + EW + 2;      // offset numerator
  localparam int QTW         = COORD_WIDTH + 2;   // quotient bits kept
  localparam int DRW         = NUMW - QTW;        // divider remainder
  localparam int SUMW        = COORD_WIDTH + 4;

  typedef struct packed {
    logic                 sneg;
    logic [NMW-1:0]       nmag;
    logic signed [EW-1:0] ex;
    logic signed [EW-1:0] ey;
    logic [LW-1:0]        len2;
    logic signed [EW-1:0] bx;
    logic signed [EW-1:0] by;
    logic                 coin;
  } tcp_geo_t;

  typedef struct packed {
    logic signed [EW-1:0] base;
    logic                 coin;
  } tcp_dtag_t;

endpackage
`default_nettype wire

// File: rtl/tcp_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_mul: pipelined unsigned multiplier
// Operands are cut into segments; partial products, row sums and the final
// sum each take one register stage.
// ----------------------------------------------------------------------------
module tcp_mul (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [tcp_pkg::MW-1:0] a,
  input  wire logic [tcp_pkg::MW-1:0] b,
  output logic      [tcp_pkg::PW-1:0] p
);
  import tcp_pkg::*;

  logic [MPW-1:0]    ae;
  logic [MPW-1:0]    be;
  logic [2*SEGW-1:0] pp       [MUL_SEGS][MUL_SEGS];
  logic [PW-1:0]     row      [MUL_SEGS];
  logic [PW-1:0]     row_next [MUL_SEGS];
  logic [PW-1:0]     p_next;

  assign ae = MPW'(a);
  assign be = MPW'(b);

  always_comb begin
    for (int i = 0; i < MUL_SEGS; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < MUL_SEGS; j++) begin
        row_next[i] = row_next[i] + (PW'(pp[i][j]) << (SEGW * (i + j)));
      end
    end
    p_next = '0;
    for (int i = 0; i < MUL_SEGS; i++) begin
      p_next = p_next + row[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < MUL_SEGS; i++) begin
        for (int j = 0; j < MUL_SEGS; j++) begin
          pp[i][j] <= ae[i*SEGW +: SEGW] * be[j*SEGW +: SEGW];
        end
        row[i] <= row_next[i];
      end
      p <= p_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tcp_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_sqrt: pipelined integer square root
// One result bit per stage, restoring digit method, floor of the root.
// ----------------------------------------------------------------------------
module tcp_sqrt (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [tcp_pkg::QW-1:0] rad,
  input  wire tcp_pkg::tcp_geo_t      in_tag,
  output logic                        out_valid,
  output logic      [tcp_pkg::SW-1:0] root,
  output tcp_pkg::tcp_geo_t           out_tag
);
  import tcp_pkg::*;

  logic           vld  [SW+1];
  logic [SRW-1:0] rem  [SW+1];
  logic [SW-1:0]  rt   [SW+1];
  logic [QW-1:0]  bits [SW+1];
  tcp_geo_t       tag  [SW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      rt[0]   <= '0;
      bits[0] <= rad;
      tag[0]  <= in_tag;
    end
  end

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [SRW-1:0] r4;
    logic [SRW-1:0] trial;
    logic           take;

    always_comb begin
      r4    = {rem[k][SRW-3:0], bits[k][QW-1:QW-2]};
      trial = SRW'({rt[k], 2'b01});
      take  = (r4 >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? (r4 - trial) : r4;
        rt[k+1]   <= {rt[k][SW-2:0], take};
        bits[k+1] <= {bits[k][QW-3:0], 2'b00};
        tag[k+1]  <= tag[k];
      end
    end
  end

  assign out_valid = vld[SW];
  assign root      = rt[SW];
  assign out_tag   = tag[SW];

endmodule
`default_nettype wire

// File: rtl/tcp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_div: pipelined restoring divider for the offset quotient
// Divides by twice the squared length, one quotient bit per stage. Quotients
// too large for the kept bits raise the overflow flag.
// ----------------------------------------------------------------------------
module tcp_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [tcp_pkg::NUMW-1:0] dividend,
  input  wire logic [tcp_pkg::LW-1:0]   len2,
  input  wire logic                     in_neg,
  input  wire tcp_pkg::tcp_dtag_t       in_tag,
  output logic                          out_valid,
  output logic      [tcp_pkg::QTW-1:0]  quo,
  output logic                          out_ovf,
  output logic                          out_neg,
  output tcp_pkg::tcp_dtag_t            out_tag
);
  import tcp_pkg::*;

  logic           vld [QTW+1];
  logic [DRW-1:0] rem [QTW+1];
  logic [DRW-1:0] den [QTW+1];
  logic [QTW-1:0] low [QTW+1];
  logic [QTW-1:0] q   [QTW+1];
  logic           ovf [QTW+1];
  logic           neg [QTW+1];
  tcp_dtag_t      tag [QTW+1];
  logic [DRW-1:0] den_in;

  assign den_in = DRW'({len2, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= dividend[NUMW-1:QTW];
      den[0] <= den_in;
      low[0] <= dividend[QTW-1:0];
      q[0]   <= '0;
      ovf[0] <= (dividend[NUMW-1:QTW] >= den_in);
      neg[0] <= in_neg;
      tag[0] <= in_tag;
    end
  end

  for (genvar k = 0; k < QTW; k++) begin : g_stage
    logic [DRW-1:0] r2;
    logic           take;

    always_comb begin
      r2   = {rem[k][DRW-2:0], low[k][QTW-1]};
      take = (r2 >= den[k]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? (r2 - den[k]) : r2;
        den[k+1] <= den[k];
        low[k+1] <= {low[k][QTW-2:0], 1'b0};
        q[k+1]   <= {q[k][QTW-2:0], take};
        ovf[k+1] <= ovf[k];
        neg[k+1] <= neg[k];
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = vld[QTW];
  assign quo       = q[QTW];
  assign out_ovf   = ovf[QTW];
  assign out_neg   = neg[QTW];
  assign out_tag   = tag[QTW];

endmodule
`default_nettype wire

// File: rtl/tangent_circle_place_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tangent_circle_place_top: place a circle tangent to two given circles
// Computes the exact tangent centre on the left of the line from the first
// centre to the second, rounded and saturated, in a fully pipelined datapath.
// ----------------------------------------------------------------------------
//  Channel | Dir | Beat contents
//  s_*     | in  | first_x, first_y, first_radius, second_x, second_y,
//          |     | second_radius, new_radius
//  m_*     | out | tdata: new_x, new_y; tuser: centres_coincide
//
// One beat is accepted per cycle. Most of the pipeline is the one-bit-per-stage
// square root (66 stages) and divider (34 stages) plus three 3-stage multiplier
// groups. The whole pipeline advances together and holds while the output
// register is full and m_tready is low. Reset clears all valid bits; there is
// no other state.
// ----------------------------------------------------------------------------
module tangent_circle_place_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // first_x, first_y, first_radius, second_x, second_y, second_radius,
  // new_radius (from bit 0 up), zero padded
  input  wire logic [223:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // new_x, new_y (from bit 0 up)
  output logic [63:0]       m_tdata,
  // centres_coincide
  output logic              m_tuser
);
  import tcp_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int O_FY  = CW;
  localparam int O_FR  = 2 * CW;
  localparam int O_SX  = O_FR + RAD_WIDTH;
  localparam int O_SY  = O_SX + CW;
  localparam int O_SR  = O_SY + CW;
  localparam int O_NR  = O_SR + RAD_WIDTH;
  localparam logic [QTW-1:0] LIMIT = QTW'(1) << (CW + 1);
  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  typedef struct packed {
    logic signed [EW-1:0] ex;
    logic signed [EW-1:0] ey;
    logic signed [EW-1:0] fx;
    logic signed [EW-1:0] fy;
    logic signed [EW-1:0] sx;
    logic signed [EW-1:0] sy;
    logic signed [EW-1:0] fbx;
    logic                 coin;
  } g1_t;

  logic adv;

  // ---------------- stage A: differences and radius sums
  logic signed [EW-1:0] in_fx, in_fy, in_sx, in_sy;
  logic [EW-1:0]        in_fr, in_sr, in_nr;
  logic                 a_v;
  g1_t                  a_g;
  logic [EW-1:0]        a_exm, a_eym, a_sa, a_sb;
  g1_t                  a_g_next;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_comb begin
    in_fx = EW'($signed(s_tdata[O_FY-1:0]));
    in_fy = EW'($signed(s_tdata[O_FR-1:O_FY]));
    in_sx = EW'($signed(s_tdata[O_SY-1:O_SX]));
    in_sy = EW'($signed(s_tdata[O_SR-1:O_SY]));
    in_fr = EW'(s_tdata[O_SX-1:O_FR]);
    in_sr = EW'(s_tdata[O_NR-1:O_SR]);
    in_nr = EW'(s_tdata[O_NR+RAD_WIDTH-1:O_NR]);
    a_g_next.ex   = in_sx - in_fx;
    a_g_next.ey   = in_sy - in_fy;
    a_g_next.fx   = in_fx;
    a_g_next.fy   = in_fy;
    a_g_next.sx   = in_sx;
    a_g_next.sy   = in_sy;
    a_g_next.fbx  = in_fx + $signed(in_nr);
    a_g_next.coin = (a_g_next.ex == '0) && (a_g_next.ey == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_g   <= a_g_next;
      a_exm <= a_g_next.ex[EW-1] ? EW'(-a_g_next.ex) : EW'(a_g_next.ex);
      a_eym <= a_g_next.ey[EW-1] ? EW'(-a_g_next.ey) : EW'(a_g_next.ey);
      a_sa  <= in_fr + in_nr;
      a_sb  <= in_sr + in_nr;
    end
  end

  // ---------------- multiplier group 1: squares
  logic [PW-1:0] p_exx, p_eyy, p_ka, p_kb;
  g1_t           g1_d [MUL_LAT];
  logic          g1_v [MUL_LAT];

  tcp_mul u_mul_exx (.clk(clk), .en(adv), .a(MW'(a_exm)), .b(MW'(a_exm)), .p(p_exx));
  tcp_mul u_mul_eyy (.clk(clk), .en(adv), .a(MW'(a_eym)), .b(MW'(a_eym)), .p(p_eyy));
  tcp_mul u_mul_ka  (.clk(clk), .en(adv), .a(MW'(a_sa)),  .b(MW'(a_sa)),  .p(p_ka));
  tcp_mul u_mul_kb  (.clk(clk), .en(adv), .a(MW'(a_sb)),  .b(MW'(a_sb)),  .p(p_kb));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MUL_LAT; k++) g1_v[k] <= 1'b0;
    end else if (adv) begin
      g1_v[0] <= a_v;
      for (int k = 1; k < MUL_LAT; k++) g1_v[k] <= g1_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_d[0] <= a_g;
      for (int k = 1; k < MUL_LAT; k++) g1_d[k] <= g1_d[k-1];
    end
  end

  // ---------------- stage B: squared length, choice of base circle
  logic                 b_v, b_sel, b_coin;
  logic [LW-1:0]        b_len2, b_own, b_other;
  logic signed [EW-1:0] b_ex, b_ey, b_bx, b_by;
  logic [LW-1:0]        ka, kb;
  logic                 sel;
  g1_t                  g1o;

  always_comb begin
    g1o = g1_d[MUL_LAT-1];
    ka  = p_ka[LW-1:0];
    kb  = p_kb[LW-1:0];
    sel = (ka > kb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= g1_v[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_len2  <= p_exx[LW-1:0] + p_eyy[LW-1:0];
      b_own   <= sel ? kb : ka;
      b_other <= sel ? ka : kb;
      b_sel   <= sel;
      b_ex    <= g1o.ex;
      b_ey    <= g1o.ey;
      b_bx    <= g1o.coin ? g1o.fbx : (sel ? g1o.sx : g1o.fx);
      b_by    <= (sel && !g1o.coin) ? g1o.sy : g1o.fy;
      b_coin  <= g1o.coin;
    end
  end

  // ---------------- stage C: N = L + own - other
  logic signed [NW-1:0] n_val;
  logic                 c_v;
  logic [LW-1:0]        c_own;
  tcp_geo_t             c_geo;

  assign n_val = $signed({2'b00, b_len2}) + $signed({2'b00, b_own})
               - $signed({2'b00, b_other});

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_own       <= b_own;
      c_geo.sneg  <= n_val[NW-1] ^ b_sel;
      c_geo.nmag  <= n_val[NW-1] ? NMW'(-n_val) : NMW'(n_val);
      c_geo.ex    <= b_ex;
      c_geo.ey    <= b_ey;
      c_geo.len2  <= b_len2;
      c_geo.bx    <= b_bx;
      c_geo.by    <= b_by;
      c_geo.coin  <= b_coin;
    end
  end

  // ---------------- multiplier group 2: own*L and N^2
  logic [PW-1:0] p_ol, p_nn;
  tcp_geo_t      g2_d [MUL_LAT];
  logic          g2_v [MUL_LAT];

  tcp_mul u_mul_ol (.clk(clk), .en(adv), .a(MW'(c_own)), .b(MW'(c_geo.len2)), .p(p_ol));
  tcp_mul u_mul_nn (.clk(clk), .en(adv), .a(MW'(c_geo.nmag)), .b(MW'(c_geo.nmag)),
                    .p(p_nn));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MUL_LAT; k++) g2_v[k] <= 1'b0;
    end else if (adv) begin
      g2_v[0] <= c_v;
      for (int k = 1; k < MUL_LAT; k++) g2_v[k] <= g2_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g2_d[0] <= c_geo;
      for (int k = 1; k < MUL_LAT; k++) g2_d[k] <= g2_d[k-1];
    end
  end

  // ---------------- stage D: radicand, clamped at zero
  logic signed [QW+1:0] q_diff;
  logic                 d_v;
  logic [QW-1:0]        d_rad;
  tcp_geo_t             d_geo;

  assign q_diff = $signed({2'b00, p_ol[QW-3:0], 2'b00}) - $signed({2'b00, p_nn[QW-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= g2_v[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_rad <= q_diff[QW+1] ? '0 : q_diff[QW-1:0];
      d_geo <= g2_d[MUL_LAT-1];
    end
  end

  // ---------------- square root
  logic          r_v;
  logic [SW-1:0] r_root;
  tcp_geo_t      r_geo;

  tcp_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (d_v),
    .rad      (d_rad),
    .in_tag   (d_geo),
    .out_valid(r_v),
    .root     (r_root),
    .out_tag  (r_geo)
  );

  // ---------------- multiplier group 3: numerator products
  logic [EW-1:0] r_exm, r_eym;
  logic [PW-1:0] p_nex, p_rey, p_ney, p_rex;
  tcp_geo_t      g3_d [MUL_LAT];
  logic          g3_v [MUL_LAT];

  assign r_exm = r_geo.ex[EW-1] ? EW'(-r_geo.ex) : EW'(r_geo.ex);
  assign r_eym = r_geo.ey[EW-1] ? EW'(-r_geo.ey) : EW'(r_geo.ey);

  tcp_mul u_mul_nex (.clk(clk), .en(adv), .a(MW'(r_geo.nmag)), .b(MW'(r_exm)), .p(p_nex));
  tcp_mul u_mul_rey (.clk(clk), .en(adv), .a(MW'(r_root)),     .b(MW'(r_eym)), .p(p_rey));
  tcp_mul u_mul_ney (.clk(clk), .en(adv), .a(MW'(r_geo.nmag)), .b(MW'(r_eym)), .p(p_ney));
  tcp_mul u_mul_rex (.clk(clk), .en(adv), .a(MW'(r_root)),     .b(MW'(r_exm)), .p(p_rex));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MUL_LAT; k++) g3_v[k] <= 1'b0;
    end else if (adv) begin
      g3_v[0] <= r_v;
      for (int k = 1; k < MUL_LAT; k++) g3_v[k] <= g3_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g3_d[0] <= r_geo;
      for (int k = 1; k < MUL_LAT; k++) g3_d[k] <= g3_d[k-1];
    end
  end

  // ---------------- stage E: signed numerators
  tcp_geo_t               g3o;
  logic signed [NUMW-1:0] t_nex, t_rey, t_ney, t_rex;
  logic signed [NUMW-1:0] s_nex, s_rey, s_ney, s_rex;
  logic                   ex_neg, ey_neg;
  logic                   e_v;
  logic signed [NUMW-1:0] e_numx, e_numy;
  logic [LW-1:0]          e_len2;
  tcp_dtag_t              e_tx, e_ty;

  always_comb begin
    g3o    = g3_d[MUL_LAT-1];
    ex_neg = g3o.ex[EW-1];
    ey_neg = g3o.ey[EW-1];
    t_nex  = $signed({1'b0, p_nex[NUMW-2:0]});
    t_rey  = $signed({1'b0, p_rey[NUMW-2:0]});
    t_ney  = $signed({1'b0, p_ney[NUMW-2:0]});
    t_rex  = $signed({1'b0, p_rex[NUMW-2:0]});
    s_nex  = (g3o.sneg ^ ex_neg) ? -t_nex : t_nex;
    s_rey  = ey_neg ? -t_rey : t_rey;
    s_ney  = (g3o.sneg ^ ey_neg) ? -t_ney : t_ney;
    s_rex  = ex_neg ? -t_rex : t_rex;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= g3_v[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_numx       <= s_nex - s_rey;
      e_numy       <= s_ney + s_rex;
      e_len2       <= g3o.len2;
      e_tx.base    <= g3o.bx;
      e_tx.coin    <= g3o.coin;
      e_ty.base    <= g3o.by;
      e_ty.coin    <= g3o.coin;
    end
  end

  // ---------------- stage F: rounding bias, |num| + L
  logic                f_v;
  logic [NUMW-1:0]     f_dx, f_dy;
  logic                f_nx, f_ny;
  logic [LW-1:0]       f_len2;
  tcp_dtag_t           f_tx, f_ty;
  logic [NUMW-1:0]     ax, ay;

  assign ax = e_numx[NUMW-1] ? NUMW'(-e_numx) : NUMW'(e_numx);
  assign ay = e_numy[NUMW-1] ? NUMW'(-e_numy) : NUMW'(e_numy);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (adv) begin
      f_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_dx   <= ax + NUMW'(e_len2);
      f_dy   <= ay + NUMW'(e_len2);
      f_nx   <= e_numx[NUMW-1];
      f_ny   <= e_numy[NUMW-1];
      f_len2 <= e_len2;
      f_tx   <= e_tx;
      f_ty   <= e_ty;
    end
  end

  // ---------------- dividers
  logic           qx_v, qy_v;
  logic [QTW-1:0] qx, qy;
  logic           qx_ovf, qy_ovf, qx_neg, qy_neg;
  tcp_dtag_t      qx_tag, qy_tag;

  tcp_div u_div_x (
    .clk(clk), .rst(rst), .en(adv), .in_valid(f_v), .dividend(f_dx), .len2(f_len2),
    .in_neg(f_nx), .in_tag(f_tx), .out_valid(qx_v), .quo(qx), .out_ovf(qx_ovf),
    .out_neg(qx_neg), .out_tag(qx_tag)
  );

  tcp_div u_div_y (
    .clk(clk), .rst(rst), .en(adv), .in_valid(f_v), .dividend(f_dy), .len2(f_len2),
    .in_neg(f_ny), .in_tag(f_ty), .out_valid(qy_v), .quo(qy), .out_ovf(qy_ovf),
    .out_neg(qy_neg), .out_tag(qy_tag)
  );

  // ---------------- output: clamp, add base, saturate
  logic [QTW-1:0]         cx, cy;
  logic signed [SUMW-1:0] ox, oy, sum_x, sum_y, sat_x, sat_y;

  always_comb begin
    cx = (qx_ovf || qx > LIMIT) ? LIMIT : qx;
    cy = (qy_ovf || qy > LIMIT) ? LIMIT : qy;
    ox = qx_neg ? -$signed(SUMW'(cx)) : $signed(SUMW'(cx));
    oy = qy_neg ? -$signed(SUMW'(cy)) : $signed(SUMW'(cy));
    if (qx_tag.coin) begin
      ox = '0;
      oy = '0;
    end
    sum_x = SUMW'(qx_tag.base) + ox;
    sum_y = SUMW'(qy_tag.base) + oy;
    sat_x = (sum_x > SAT_HI) ? SAT_HI : ((sum_x < SAT_LO) ? SAT_LO : sum_x);
    sat_y = (sum_y > SAT_HI) ? SAT_HI : ((sum_y < SAT_LO) ? SAT_LO : sum_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= qx_v && qy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {sat_y[CW-1:0], sat_x[CW-1:0]};
      m_tuser <= qx_tag.coin;
    end
  end

endmodule
`default_nettype wire

// File: tb/tangent_circle_place_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tangent_circle_place_top_tb: self-checking bench for the tangent placer
// Streams directed and random circle pairs through the block under random
// idling on both sides. Each output beat is compared with an exact
// wide-integer computation of the tangent centre.
// ----------------------------------------------------------------------------
module tangent_circle_place_top_tb;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               coin;
  } place_t;

  class placement_board;
    place_t placed_q[$];
    int     mismatches;
    int     checked;
    int     coincident_seen;
    int     clamped_seen;

    function logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function wide_t root_floor(wide_t v);
      logic [127:0] root;
      logic [127:0] cand;
      logic [255:0] sq;
      root = '0;
      for (int b = 127; b >= 0; b--) begin
        cand = root;
        cand[b] = 1'b1;
        sq = {128'b0, cand} * {128'b0, cand};
        if (sq <= v) root = cand;
      end
      return wide_t'({128'b0, root});
    endfunction

    // Rounds num / (2 * len2) half away from zero and clamps it to +-2^33.
    function longint offset(wide_t num, wide_t len2);
      wide_t mag;
      wide_t q;
      mag = num < 0 ? -num : num;
      q = (mag + len2) / (len2 + len2);
      if (q > wide_t'(64'sd8589934592)) q = wide_t'(64'sd8589934592);
      return num < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function void note_input(logic [223:0] d);
      logic signed [31:0] fx, fy, sx, sy;
      logic [30:0] fr, sr, nr;
      wide_t ex, ey, len2, ka, kb, own, other, nn, qq, root, numx, numy;
      longint bx, by;
      place_t p;
      fx = d[31:0]; fy = d[63:32]; fr = d[94:64];
      sx = d[126:95]; sy = d[158:127]; sr = d[189:159]; nr = d[220:190];
      ex = wide_t'(sx) - wide_t'(fx);
      ey = wide_t'(sy) - wide_t'(fy);
      if (ex == 0 && ey == 0) begin
        p.x = sat32(longint'(fx) + longint'({33'b0, nr}));
        p.y = fy;
        p.coin = 1'b1;
        coincident_seen++;
      end else begin
        len2 = ex * ex + ey * ey;
        ka = (wide_t'(fr) + wide_t'(nr)) * (wide_t'(fr) + wide_t'(nr));
        kb = (wide_t'(sr) + wide_t'(nr)) * (wide_t'(sr) + wide_t'(nr));
        if (ka > kb) begin
          bx = sx; by = sy; own = kb; other = ka;
        end else begin
          bx = fx; by = fy; own = ka; other = kb;
        end
        nn = len2 + own - other;
        qq = 4 * own * len2 - nn * nn;
        if (qq < 0) begin
          qq = 0;
          clamped_seen++;
        end
        root = root_floor(qq);
        if (ka > kb) nn = -nn;
        numx = nn * ex - root * ey;
        numy = nn * ey + root * ex;
        p.x = sat32(bx + offset(numx, len2));
        p.y = sat32(by + offset(numy, len2));
        p.coin = 1'b0;
      end
      placed_q.insert(placed_q.size(), p);
    endfunction

    function void check_result(logic [63:0] d, logic coin);
      place_t p;
      checked++;
      if (placed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat: %h coin %b", d, coin);
        return;
      end
      p = placed_q.pop_front();
      if (p.x !== d[31:0] || p.y !== d[63:32] || p.coin !== coin) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected x %0d y %0d coin %b, got x %0d y %0d coin %b",
                   p.x, p.y, p.coin, $signed(d[31:0]), $signed(d[63:32]), coin);
      end
    endfunction

    function int pending();
      return placed_q.size();
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [223:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;
  logic         m_tuser;

  placement_board board;
  int           stall_left;
  int           ready_wait;
  bit           burst_mode;
  int           sent;

  tangent_circle_place_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", board.pending());
    $display("== FAIL ==");
    $finish;
  end

  // Output side: outside burst mode, a new stall length is drawn after every accepted beat.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      board.check_result(m_tdata, m_tuser);
      if (burst_mode) begin
        m_tready <= 1'b1;
      end else begin
        ready_wait = $urandom_range(0, 9);
        stall_left <= (ready_wait > 0) ? ready_wait - 1 : 0;
        m_tready <= (ready_wait == 0);
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [223:0] pack_pair(logic [31:0] fx, logic [31:0] fy,
                                             logic [30:0] fr, logic [31:0] sx,
                                             logic [31:0] sy, logic [30:0] sr,
                                             logic [30:0] nr);
    return {3'b0, nr, sr, sy, sx, fr, fy, fx};
  endfunction

  task automatic send_pair(logic [223:0] d);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_input(d);
    sent++;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Circles of modest size near each other, so that most pairs have a real
  // tangent point and the square root sees non-trivial radicands.
  task automatic send_near_pair();
    logic [31:0] fx, fy;
    logic [30:0] fr, sr, nr;
    int span;
    span = 1 << $urandom_range(4, 26);
    fx = $urandom;
    fy = $urandom;
    fr = 31'($urandom_range(0, span));
    sr = 31'($urandom_range(0, span));
    nr = 31'($urandom_range(0, span));
    send_pair(pack_pair(fx, fy, fr,
                        fx + $urandom_range(0, 4 * span) - 2 * span,
                        fy + $urandom_range(0, 4 * span) - 2 * span, sr, nr));
  endtask

  initial begin
    logic [31:0] ax, ay;
    int mode;
    board = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    burst_mode = 1'b0;
    sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: coincident centres, field extremes, equal combined distances,
    // circles too far apart for a tangent point, and saturating placements.
    send_pair(pack_pair(0, 0, 0, 0, 0, 0, 0));
    send_pair(pack_pair(32'h12345678, 32'h80000000, 5, 32'h12345678, 32'h80000000, 9,
                        31'h7fffffff));
    send_pair(pack_pair(32'h7fffffff, 32'h7fffffff, 0, 32'h7fffffff, 32'h7fffffff, 0,
                        31'h7fffffff));
    send_pair(pack_pair(32'h80000000, 32'h80000000, 31'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 31'h7fffffff, 31'h7fffffff));
    send_pair(pack_pair(32'h7fffffff, 32'h7fffffff, 0, 32'h80000000, 32'h80000000, 0, 0));
    send_pair(pack_pair(0, 0, 4096, 8192, 0, 4096, 4096));
    send_pair(pack_pair(0, 0, 4096, 8192, 0, 4096, 0));
    send_pair(pack_pair(0, 0, 100, 1000000, 0, 100, 50));
    send_pair(pack_pair(0, 0, 100, 0, 50000, 300, 50));
    send_pair(pack_pair(0, 0, 300, 0, 500, 100, 50));
    send_pair(pack_pair(0, 0, 1, 1, 0, 1, 31'h7fffffff));
    send_pair(pack_pair(32'h7ffff000, 0, 1, 32'h7fffffff, 1, 1, 31'h40000000));
    send_pair(pack_pair(32'h80000000, 0, 31'h7fffffff, 32'h80000001, 0, 0, 31'h7fffffff));
    send_pair(pack_pair(32'hfffff000, 32'h00001000, 2048, 32'h00001000, 32'hfffff000,
                        2048, 1024));
    send_pair(pack_pair(32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 31'h7fffffff, 31'h7fffffff));
    send_pair(pack_pair(32'h00010000, 32'h00020000, 31'h00003000, 32'h00018000,
                        32'h00024000, 31'h00002000, 31'h00001000));

    // Hold off the sender until the pipeline has drained completely.
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    for (int i = 0; i < 1700; i++) begin
      if (i % 200 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        send_near_pair();
      end else if (mode == 6) begin
        ax = $urandom;
        ay = $urandom;
        send_pair(pack_pair(ax, ay, 31'($urandom), ax, ay, 31'($urandom),
                            31'($urandom)));
      end else begin
        send_pair(pack_pair($urandom, $urandom, 31'($urandom), $urandom, $urandom,
                            31'($urandom), 31'($urandom)));
      end
    end
    s_tvalid <= 1'b0;
    burst_mode = 1'b0;

    for (int w = 0; w < 200000 && board.pending() != 0; w++) @(posedge clk);
    repeat (130) @(posedge clk);

    $display("Sent %0d placements, checked %0d output beats, %0d mismatches.",
             sent, board.checked, board.mismatches);
    $display("Coincident-centre cases: %0d, clamped radicands: %0d.",
             board.coincident_seen, board.clamped_seen);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: tangent_circle_place_top.f
rtl/tcp_pkg.sv
rtl/tcp_mul.sv
rtl/tcp_sqrt.sv
rtl/tcp_div.sv
rtl/tangent_circle_place_top.sv
tb/tangent_circle_place_top_tb.sv
